>>> sv/bfbs_pkg.sv
// ----------------------------------------------------------------------------
// bfbs_pkg
// Shared types and constants for the bloom filter bit store.
// ----------------------------------------------------------------------------
`default_nettype none

package bfbs_pkg;

    // Default filter size in bits (power of two)
    localparam int unsigned FILTER_BITS_DEF = 1048576;

    // The bit store is kept in rows of this many bits
    localparam int unsigned ROW_BITS = 64;

    // Field and counter widths
    localparam int unsigned KIND_W     = 2;
    localparam int unsigned HASH_W     = 64;
    localparam int unsigned REPORT_W   = 32;
    localparam int unsigned PROBE_W    = 8;
    localparam int unsigned RATE_W     = 24;
    localparam int unsigned THRESH_W   = 40;
    localparam int unsigned TOTAL_W    = 48;
    localparam int unsigned ENTRY_W    = 32;
    localparam int unsigned PRODUCT_W  = RATE_W + TOTAL_W;
    localparam int unsigned HALF_W     = TOTAL_W / 2;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 40;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_MATCH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPORT = 2'd2;

    // Result kinds
    localparam logic RES_MATCH  = 1'b0;
    localparam logic RES_REPORT = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;

    // Reset values and limits
    localparam logic [RATE_W-1:0]   RATE_RESET   = 24'd100000;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 40'd500000;
    localparam logic [PROBE_W-1:0]  PROBE_MAX    = '1;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX    = '1;
    localparam logic [ENTRY_W-1:0]  ENTRY_MAX    = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RMW,
        S_MUL_LO,
        S_MUL_HI,
        S_CMP
    } t_state;

endpackage

`default_nettype wire

>>> sv/bfbs_ram.sv
// ----------------------------------------------------------------------------
// bfbs_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bfbs_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> sv/bloom_filter_bit_store.sv
// ----------------------------------------------------------------------------
// bloom_filter_bit_store
// Bloom filter bit store: match / add of precomputed hash words and
// false-positive quality reporting.
//
// Flow: a hash word gets a row read, then a modify/write of the row; a match
//   result strobes in the cycle after the modify. A report item passes through
//   S_MUL_LO, S_MUL_HI and S_CMP. A new item is taken only while idle (a hash
//   word holds the single bit-store RAM for its read-modify-write; a report
//   uses the shared 24x24 multiplier twice). Reset: synchronous, active low;
//   busy stays high while the store is swept to zero. Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_bit_store
    import bfbs_pkg::*;
#(
    parameter int unsigned FILTER_BITS = FILTER_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // Item channel
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [KIND_W-1:0]     i_kind,
    input  wire logic [HASH_W-1:0]     i_hash_word,
    input  wire logic                  i_last,
    input  wire logic [REPORT_W-1:0]   i_false_positive_report,

    // Result channel
    output logic                       o_result_valid,
    output logic                       o_result_kind,
    output logic                       o_found,
    output logic [PROBE_W-1:0]         o_probes_checked,
    output logic                       o_filter_poor,

    // Configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Bit index splits into a row address and a bit select within the row
    localparam int unsigned IDX_W  = $clog2(FILTER_BITS);
    localparam int unsigned SEL_W  = $clog2(ROW_BITS);
    localparam int unsigned ROW_AW = IDX_W - SEL_W;
    localparam int unsigned ROWS   = FILTER_BITS / ROW_BITS;

    // Control state
    t_state              r_state, n_state;
    logic [ROW_AW-1:0]   r_clr_addr, n_clr_addr;
    logic                r_miss_seen, n_miss_seen;
    logic                r_new_bit_seen, n_new_bit_seen;
    logic [PROBE_W-1:0]  r_probe_count, n_probe_count;
    logic [TOTAL_W-1:0]  r_pos_total, n_pos_total;
    logic [ENTRY_W-1:0]  r_entry_total, n_entry_total;
    logic [TOTAL_W-1:0]  r_fp_total, n_fp_total;
    logic [RATE_W-1:0]   r_rate, n_rate;
    logic [THRESH_W-1:0] r_thresh, n_thresh;
    logic                r_out_valid, n_out_valid;

    // Payload held for the word in flight and for the result
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic                r_last, n_last;
    logic [ROW_AW-1:0]   r_row_addr, n_row_addr;
    logic [SEL_W-1:0]    r_bit_sel, n_bit_sel;
    logic [TOTAL_W-1:0]  r_prod_lo, n_prod_lo;
    logic [TOTAL_W-1:0]  r_prod_hi, n_prod_hi;
    logic                r_out_kind, n_out_kind;
    logic                r_out_found, n_out_found;
    logic [PROBE_W-1:0]  r_out_probes, n_out_probes;
    logic                r_out_poor, n_out_poor;

    // RAM ports
    logic                ram_we;
    logic [ROW_AW-1:0]   ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [ROW_AW-1:0]   ram_raddr;
    logic [ROW_BITS-1:0] ram_rdata;

    // Shared multiplier and quality compare
    logic [HALF_W-1:0]    mul_b;
    logic [TOTAL_W-1:0]   mul_p;
    logic [PRODUCT_W-1:0] rate_product;
    logic                 accept;
    logic [TOTAL_W:0]     fp_sum;

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    // Take a register write only while nothing is in flight or starting
    assign o_cfg_ready = !busy && !start;

    // The row address is taken straight from the hash word's low bits
    assign ram_raddr = i_hash_word[IDX_W-1:SEL_W];

    // Pick the half of the false-positive total for this pass
    assign mul_b = (r_state == S_MUL_LO) ? r_fp_total[HALF_W-1:0]
                                         : r_fp_total[TOTAL_W-1:HALF_W];
    assign mul_p = r_rate * mul_b;

    // rate * fp_total = (hi << 24) + lo
    assign rate_product = {r_prod_hi, {HALF_W{1'b0}}}
                        + {{(PRODUCT_W - TOTAL_W){1'b0}}, r_prod_lo};

    assign fp_sum = {1'b0, r_fp_total} + (TOTAL_W + 1)'(i_false_positive_report);

    bfbs_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROWS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr_addr     <= '0;
            r_miss_seen    <= 1'b0;
            r_new_bit_seen <= 1'b0;
            r_probe_count  <= '0;
            r_pos_total    <= '0;
            r_entry_total  <= '0;
            r_fp_total     <= '0;
            r_rate         <= RATE_RESET;
            r_thresh       <= THRESH_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr_addr     <= n_clr_addr;
            r_miss_seen    <= n_miss_seen;
            r_new_bit_seen <= n_new_bit_seen;
            r_probe_count  <= n_probe_count;
            r_pos_total    <= n_pos_total;
            r_entry_total  <= n_entry_total;
            r_fp_total     <= n_fp_total;
            r_rate         <= n_rate;
            r_thresh       <= n_thresh;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_last       <= n_last;
        r_row_addr   <= n_row_addr;
        r_bit_sel    <= n_bit_sel;
        r_prod_lo    <= n_prod_lo;
        r_prod_hi    <= n_prod_hi;
        r_out_kind   <= n_out_kind;
        r_out_found  <= n_out_found;
        r_out_probes <= n_out_probes;
        r_out_poor   <= n_out_poor;
    end

    always_comb begin
        logic rd_bit;
        logic miss_next;
        logic new_next;

        n_state        = r_state;
        n_clr_addr     = r_clr_addr;
        n_miss_seen    = r_miss_seen;
        n_new_bit_seen = r_new_bit_seen;
        n_probe_count  = r_probe_count;
        n_pos_total    = r_pos_total;
        n_entry_total  = r_entry_total;
        n_fp_total     = r_fp_total;
        n_rate         = r_rate;
        n_thresh       = r_thresh;
        n_out_valid    = 1'b0;
        n_kind         = r_kind;
        n_last         = r_last;
        n_row_addr     = r_row_addr;
        n_bit_sel      = r_bit_sel;
        n_prod_lo      = r_prod_lo;
        n_prod_hi      = r_prod_hi;
        n_out_kind     = r_out_kind;
        n_out_found    = r_out_found;
        n_out_probes   = r_out_probes;
        n_out_poor     = r_out_poor;
        ram_we         = 1'b0;
        ram_waddr      = r_row_addr;
        ram_wdata      = ram_rdata;
        rd_bit         = ram_rdata[r_bit_sel];
        miss_next      = r_miss_seen;
        new_next       = r_new_bit_seen;

        // Configuration writes land only when the block is quiet
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RATE:   n_rate   = i_cfg_data[RATE_W-1:0];
                CFG_THRESH: n_thresh = i_cfg_data[THRESH_W-1:0];
                default:    ;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                // Sweep the store to zero, one row a cycle
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ROW_AW'(ROWS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_kind     = i_kind;
                    n_last     = i_last;
                    n_row_addr = i_hash_word[IDX_W-1:SEL_W];
                    n_bit_sel  = i_hash_word[SEL_W-1:0];
                    case (i_kind)
                        KIND_MATCH, KIND_ADD: begin
                            // Row read issued now; modify next cycle
                            n_state = S_RMW;
                        end
                        KIND_REPORT: begin
                            // Add the report, saturating
                            n_fp_total = fp_sum[TOTAL_W] ? TOTAL_MAX
                                                         : fp_sum[TOTAL_W-1:0];
                            n_state    = S_MUL_LO;
                        end
                        default: ;  // drop the unused kind
                    endcase
                end
            end

            S_RMW: begin
                n_state = S_IDLE;
                if (r_kind == KIND_MATCH) begin
                    // Probe only until the first clear bit
                    if (!r_miss_seen) begin
                        if (r_probe_count != PROBE_MAX) begin
                            n_probe_count = r_probe_count + 1'b1;
                        end
                        if (!rd_bit) begin
                            miss_next = 1'b1;
                        end
                    end
                    n_miss_seen = miss_next;
                    if (r_last) begin
                        n_out_valid  = 1'b1;
                        n_out_kind   = RES_MATCH;
                        n_out_found  = !miss_next;
                        n_out_probes = n_probe_count;
                        n_out_poor   = 1'b0;
                        if (!miss_next && r_pos_total != TOTAL_MAX) begin
                            n_pos_total = r_pos_total + 1'b1;
                        end
                    end
                end else begin
                    // Add: set the bit and write the row back
                    ram_we    = 1'b1;
                    ram_wdata = ram_rdata | (ROW_BITS'(1) << r_bit_sel);
                    if (!rd_bit) begin
                        new_next = 1'b1;
                    end
                    n_new_bit_seen = new_next;
                    if (r_last && new_next && r_entry_total != ENTRY_MAX) begin
                        n_entry_total = r_entry_total + 1'b1;
                    end
                end
                // The last word ends the element
                if (r_last) begin
                    n_miss_seen    = 1'b0;
                    n_new_bit_seen = 1'b0;
                    n_probe_count  = '0;
                end
            end

            S_MUL_LO: begin
                n_prod_lo = mul_p;
                n_state   = S_MUL_HI;
            end

            S_MUL_HI: begin
                n_prod_hi = mul_p;
                n_state   = S_CMP;
            end

            S_CMP: begin
                // positives > threshold and positives < rate * false positives
                n_out_valid  = 1'b1;
                n_out_kind   = RES_REPORT;
                n_out_found  = 1'b0;
                n_out_probes = '0;
                n_out_poor   = ({{(TOTAL_W - THRESH_W){1'b0}}, r_thresh} < r_pos_total)
                            && ({{(PRODUCT_W - TOTAL_W){1'b0}}, r_pos_total} < rate_product);
                n_state      = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result_valid   = r_out_valid;
    assign o_result_kind    = r_out_kind;
    assign o_found          = r_out_found;
    assign o_probes_checked = r_out_probes;
    assign o_filter_poor    = r_out_poor;

    // A result only follows a modify cycle or the quality compare
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_RMW || $past(r_state) == S_CMP))
        else $error("result strobe without a finishing cycle");

    // The store is never written while the block is idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_we)
        else $error("bit store written while idle");

    // A miss can only be recorded after at least one probe
    a_miss_probed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_miss_seen |-> (r_probe_count != '0))
        else $error("miss recorded with no probe");

    // A found match has probed at least one bit
    a_found_probes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result_kind == RES_MATCH && o_found)
            |-> (o_probes_checked != '0))
        else $error("found match with zero probes");

    // The positive count never goes backward
    a_pos_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_pos_total >= $past(r_pos_total)))
        else $error("positive total decreased");

endmodule

`default_nettype wire
